FILE: rtl/core/rpl_pkg.sv
`default_nettype none
package rpl_pkg;

  localparam int unsigned SpanW = 13;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MaxRes = 3;

  typedef enum logic [2:0] {
    PH_START     = 3'd0,
    PH_ESC       = 3'd1,
    PH_LIT       = 3'd2,
    PH_RANGE     = 3'd3,
    PH_RANGE_ESC = 3'd4,
    PH_REP       = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    K_END    = 4'd0,
    K_LIT    = 4'd1,
    K_RANGE  = 4'd2,
    K_COPEN  = 4'd3,
    K_CCLOSE = 4'd4,
    K_LPAREN = 4'd5,
    K_RPAREN = 4'd6,
    K_PLUS   = 4'd7,
    K_QUEST  = 4'd8,
    K_STAR   = 4'd9,
    K_ANY    = 4'd10,
    K_CARET  = 4'd11,
    K_DOLLAR = 4'd12,
    K_BAR    = 4'd13,
    K_REP    = 4'd14,
    K_BAD    = 4'd15
  } kind_t;

  typedef enum logic [3:0] {
    E_NONE       = 4'd0,
    E_TRAIL_ESC  = 4'd1,
    E_INVALID    = 4'd2,
    E_BAD_RANGE  = 4'd3,
    E_STRAY      = 4'd4,
    E_EMPTY_REP  = 4'd5,
    E_COMMA      = 4'd6,
    E_DIGIT      = 4'd7,
    E_OPEN_REP   = 4'd8
  } err_t;

  localparam logic [CfgIdxW-1:0] REG_PRINT_LO = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PRINT_HI = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SPACE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPACE_HI = 2'd3;

  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DASH   = 8'h2D;

  typedef struct packed {
    logic [7:0] pattern_char;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    kind_t            token_kind;
    err_t             error_code;
    logic [SpanW-1:0] span_start;
    logic [SpanW-1:0] span_stop;
    logic [7:0]       low_char;
    logic [7:0]       high_char;
    logic             newline_flag;
    logic             run_end;
  } out_item_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // unescaped single-char operators; K_BAD means none
  function automatic kind_t simple_kind(input logic [7:0] c);
    case (c)
      8'h28: return K_LPAREN;
      8'h29: return K_RPAREN;
      8'h2B: return K_PLUS;
      8'h3F: return K_QUEST;
      8'h2A: return K_STAR;
      8'h2E: return K_ANY;
      8'h5E: return K_CARET;
      8'h24: return K_DOLLAR;
      8'h7C: return K_BAR;
      default: return K_BAD;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/regex_pattern_lexer.sv
`default_nettype none
// Regex pattern lexer: one pattern byte per transfer in (is_last marks the
// final byte), tokens out, each with kind, error code, text span and char
// values; run_end marks the last token caused by a byte. Every byte is decoded
// combinationally between the input handshake and a three-entry result queue,
// so a byte can be taken every cycle while out_stall is low and each byte
// yields at most one token; else input stalls until the last token goes out.
// Plain literals are held back one byte (range detection), so a literal token
// appears on the byte after it. After an error, bytes are dropped up to and
// including the next last mark. Registers 0..3 set the printable and
// whitespace ranges and may only be written while the block is idle.
module regex_pattern_lexer #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  rpl_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output rpl_pkg::out_item_t               out_data,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [rpl_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire [7:0]                        cfg_data
);

  localparam int unsigned PW = $clog2(MAX_LEN + 1);
  localparam logic [PW-1:0] PosMax = PW'(MAX_LEN);

  logic [7:0] print_lo, print_hi, space_lo, space_hi;

  rpl_pkg::phase_t lex_phase, ph;
  logic in_class, icl;
  logic saw_newline, nl;
  logic comma_seen, cs;
  logic [7:0] held_char, hc;
  logic [7:0] prev_char, pc;
  logic [7:0] first_after_brace, fab;
  logic [7:0] range_low, rlc;
  logic [PW-1:0] position, token_start, ts, pos_n;
  logic error_latched, el;

  rpl_pkg::out_item_t ev [4];
  logic [3:0] ev_v;
  rpl_pkg::out_item_t res [rpl_pkg::MaxRes];
  logic [1:0] res_n;

  rpl_pkg::out_item_t qbuf [rpl_pkg::MaxRes];
  logic [1:0] qcnt;

  logic in_xfer, out_xfer;
  logic [7:0] c;
  logic [PW:0] ts_plus1;
  rpl_pkg::kind_t sk;

  function automatic logic is_print(input logic [7:0] ch, input logic [7:0] plo,
                                    input logic [7:0] phi, input logic [7:0] slo,
                                    input logic [7:0] shi);
    return ((ch >= plo) && (ch <= phi)) || ((ch >= slo) && (ch <= shi));
  endfunction

  function automatic logic [PW-1:0] after(input logic [PW-1:0] p);
    return (p < PosMax) ? p + 1'b1 : p;
  endfunction

  function automatic rpl_pkg::out_item_t mk(input rpl_pkg::kind_t k, input rpl_pkg::err_t e,
                                            input logic [PW-1:0] s, input logic [PW-1:0] t,
                                            input logic [7:0] lo, input logic [7:0] hi,
                                            input logic n);
    rpl_pkg::out_item_t r;
    r.token_kind   = k;
    r.error_code   = e;
    r.span_start   = rpl_pkg::SpanW'(s);
    r.span_stop    = rpl_pkg::SpanW'(t);
    r.low_char     = lo;
    r.high_char    = hi;
    r.newline_flag = n;
    r.run_end      = 1'b0;
    return r;
  endfunction

  assign c         = in_data.pattern_char;
  assign in_stall  = !((qcnt == 2'd0) || ((qcnt == 2'd1) && !out_stall));
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (qcnt != 2'd0);
  assign out_xfer  = out_valid && !out_stall;
  assign out_data  = qbuf[0];
  assign cfg_ready = 1'b1;
  assign ts_plus1  = {1'b0, token_start} + 1'b1;
  assign sk        = rpl_pkg::simple_kind(c);

  // one byte of lexing, events in emit order:
  // ev0 flushed literal, ev1 token of this byte, ev2 finish token, ev3 end
  always_comb begin
    ph = lex_phase; icl = in_class; nl = saw_newline; cs = comma_seen;
    hc = held_char; pc = prev_char; fab = first_after_brace;
    rlc = range_low; ts = token_start; el = error_latched;
    pos_n = after(position);
    ev_v = '0;
    for (int i = 0; i < 4; i++) begin
      ev[i] = mk(rpl_pkg::K_END, rpl_pkg::E_NONE, '0, '0, 8'd0, 8'd0, 1'b0);
    end

    if (!error_latched) begin
      case (lex_phase)
        rpl_pkg::PH_LIT, rpl_pkg::PH_START, rpl_pkg::PH_ESC: begin
          if (lex_phase == rpl_pkg::PH_LIT && c == rpl_pkg::CH_DASH && in_class) begin
            rlc = held_char;
            ph = rpl_pkg::PH_RANGE;
          end else begin
            if (lex_phase == rpl_pkg::PH_LIT) begin
              ev_v[0] = 1'b1;
              ev[0] = mk(rpl_pkg::K_LIT, rpl_pkg::E_NONE, token_start, position,
                         held_char, held_char, saw_newline);
            end
            ts = position;
            ph = rpl_pkg::PH_START;
            if (lex_phase != rpl_pkg::PH_ESC && c == rpl_pkg::CH_BSLASH) begin
              ph = rpl_pkg::PH_ESC;
            end else if (lex_phase != rpl_pkg::PH_ESC && c == rpl_pkg::CH_RBRACK) begin
              ev_v[1] = 1'b1;
              ev[1] = mk(rpl_pkg::K_CCLOSE, rpl_pkg::E_NONE, position, pos_n,
                         8'd0, 8'd0, nl);
              icl = 1'b0;
            end else if (lex_phase != rpl_pkg::PH_ESC && !in_class &&
                         (sk != rpl_pkg::K_BAD || c == rpl_pkg::CH_LBRACK ||
                          c == rpl_pkg::CH_LBRACE || c == rpl_pkg::CH_RBRACE)) begin
              if (c == rpl_pkg::CH_LBRACK) begin
                ev_v[1] = 1'b1;
                ev[1] = mk(rpl_pkg::K_COPEN, rpl_pkg::E_NONE, position, pos_n,
                           8'd0, 8'd0, nl);
                icl = 1'b1;
              end else if (c == rpl_pkg::CH_LBRACE) begin
                cs = 1'b0;
                fab = 8'd0;
                ph = rpl_pkg::PH_REP;
              end else if (c == rpl_pkg::CH_RBRACE) begin
                ev_v[1] = 1'b1;
                ev[1] = mk(rpl_pkg::K_BAD, rpl_pkg::E_STRAY, ts, pos_n, 8'd0, 8'd0, nl);
                el = 1'b1;
              end else begin
                ev_v[1] = 1'b1;
                ev[1] = mk(sk, rpl_pkg::E_NONE, position, pos_n, 8'd0, 8'd0, nl);
              end
            end else if (lex_phase == rpl_pkg::PH_ESC ||
                         sk != rpl_pkg::K_BAD || c == rpl_pkg::CH_LBRACK ||
                         c == rpl_pkg::CH_LBRACE || c == rpl_pkg::CH_RBRACE ||
                         is_print(c, print_lo, print_hi, space_lo, space_hi)) begin
              // hold: escaped bytes, class symbols and printable bytes
              if (c == rpl_pkg::CH_NL) begin
                nl = 1'b1;
              end
              if (c == rpl_pkg::CH_DASH && in_class && prev_char != rpl_pkg::CH_BSLASH) begin
                ev_v[1] = 1'b1;
                ev[1] = mk(rpl_pkg::K_BAD, rpl_pkg::E_BAD_RANGE, ts, pos_n,
                           8'd0, 8'd0, nl);
                el = 1'b1;
              end else begin
                hc = c;
                ph = rpl_pkg::PH_LIT;
              end
            end else begin
              ev_v[1] = 1'b1;
              ev[1] = mk(rpl_pkg::K_BAD, rpl_pkg::E_INVALID, ts, pos_n, 8'd0, 8'd0, nl);
              el = 1'b1;
            end
          end
        end
        rpl_pkg::PH_RANGE, rpl_pkg::PH_RANGE_ESC: begin
          if (lex_phase == rpl_pkg::PH_RANGE && c == rpl_pkg::CH_BSLASH) begin
            ph = rpl_pkg::PH_RANGE_ESC;
          end else if (is_print(c, print_lo, print_hi, space_lo, space_hi) &&
                       (lex_phase == rpl_pkg::PH_RANGE_ESC ||
                        (c != rpl_pkg::CH_LBRACK && c != rpl_pkg::CH_RBRACK))) begin
            ev_v[1] = 1'b1;
            ev[1] = mk(rpl_pkg::K_RANGE, rpl_pkg::E_NONE, ts, pos_n, range_low, c, nl);
            ph = rpl_pkg::PH_START;
          end else begin
            ev_v[1] = 1'b1;
            ev[1] = mk(rpl_pkg::K_BAD, rpl_pkg::E_BAD_RANGE, ts, pos_n, 8'd0, 8'd0, nl);
            el = 1'b1;
          end
        end
        rpl_pkg::PH_REP: begin
          if ({1'b0, position} == ts_plus1) begin
            fab = c;
          end
          if (c == rpl_pkg::CH_RBRACE) begin
            if (!rpl_pkg::is_digit(prev_char) && !rpl_pkg::is_digit(fab)) begin
              ev_v[1] = 1'b1;
              ev[1] = mk(rpl_pkg::K_BAD, rpl_pkg::E_EMPTY_REP, ts, pos_n,
                         8'd0, 8'd0, nl);
              el = 1'b1;
            end else begin
              ev_v[1] = 1'b1;
              ev[1] = mk(rpl_pkg::K_REP, rpl_pkg::E_NONE, ts, pos_n, 8'd0, 8'd0, nl);
              ph = rpl_pkg::PH_START;
            end
          end else if (c == rpl_pkg::CH_COMMA) begin
            if (comma_seen) begin
              ev_v[1] = 1'b1;
              ev[1] = mk(rpl_pkg::K_BAD, rpl_pkg::E_COMMA, ts, pos_n, 8'd0, 8'd0, nl);
              el = 1'b1;
            end else begin
              cs = 1'b1;
            end
          end else if (!rpl_pkg::is_digit(c)) begin
            ev_v[1] = 1'b1;
            ev[1] = mk(rpl_pkg::K_BAD, rpl_pkg::E_DIGIT, ts, pos_n, 8'd0, 8'd0, nl);
            el = 1'b1;
          end
        end
        default: ;
      endcase
      pc = c;

      if (in_data.is_last && !el) begin
        case (ph)
          rpl_pkg::PH_LIT: begin
            ev_v[2] = 1'b1;
            ev[2] = mk(rpl_pkg::K_LIT, rpl_pkg::E_NONE, ts, pos_n, hc, hc, nl);
          end
          rpl_pkg::PH_ESC, rpl_pkg::PH_RANGE_ESC: begin
            ev_v[2] = 1'b1;
            ev[2] = mk(rpl_pkg::K_BAD, rpl_pkg::E_TRAIL_ESC, ts, pos_n, 8'd0, 8'd0, nl);
            el = 1'b1;
          end
          rpl_pkg::PH_RANGE: begin
            ev_v[2] = 1'b1;
            ev[2] = mk(rpl_pkg::K_BAD, rpl_pkg::E_NONE, ts, pos_n, 8'd0, 8'd0, nl);
          end
          rpl_pkg::PH_REP: begin
            ev_v[2] = 1'b1;
            ev[2] = mk(rpl_pkg::K_BAD, rpl_pkg::E_OPEN_REP, ts, pos_n, 8'd0, 8'd0, nl);
            el = 1'b1;
          end
          default: ;
        endcase
        if (!el) begin
          ev_v[3] = 1'b1;
          ev[3] = mk(rpl_pkg::K_END, rpl_pkg::E_NONE, pos_n, pos_n, 8'd0, 8'd0, nl);
        end
      end
    end
  end

  // pack events into result slots, at most three kept
  always_comb begin
    res_n = 2'd0;
    for (int i = 0; i < rpl_pkg::MaxRes; i++) begin
      res[i] = ev[3];
    end
    for (int i = 0; i < 4; i++) begin
      if (ev_v[i] && res_n != 2'd3) begin
        res[res_n] = ev[i];
        res_n = res_n + 2'd1;
      end
    end
    for (int i = 0; i < rpl_pkg::MaxRes; i++) begin
      res[i].run_end = (2'(i + 1) == res_n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      print_lo <= 8'd32;
      print_hi <= 8'd126;
      space_lo <= 8'd9;
      space_hi <= 8'd13;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rpl_pkg::REG_PRINT_LO: print_lo <= cfg_data;
        rpl_pkg::REG_PRINT_HI: print_hi <= cfg_data;
        rpl_pkg::REG_SPACE_LO: space_lo <= cfg_data;
        rpl_pkg::REG_SPACE_HI: space_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_xfer && in_data.is_last)) begin
      lex_phase <= rpl_pkg::PH_START;
      in_class <= 1'b0;
      saw_newline <= 1'b0;
      comma_seen <= 1'b0;
      held_char <= 8'd0;
      prev_char <= 8'd0;
      first_after_brace <= 8'd0;
      range_low <= 8'd0;
      position <= '0;
      token_start <= '0;
      error_latched <= 1'b0;
    end else if (in_xfer && !error_latched) begin
      lex_phase <= ph;
      in_class <= icl;
      saw_newline <= nl;
      comma_seen <= cs;
      held_char <= hc;
      prev_char <= pc;
      first_after_brace <= fab;
      range_low <= rlc;
      position <= pos_n;
      token_start <= ts;
      error_latched <= el;
    end
  end

  // result queue, head at entry 0
  always_ff @(posedge clk) begin
    if (rst) begin
      qcnt <= 2'd0;
    end else if (in_xfer) begin
      qcnt <= res_n;
    end else if (out_xfer) begin
      qcnt <= qcnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < rpl_pkg::MaxRes; i++) begin
        qbuf[i] <= res[i];
      end
    end else if (out_xfer) begin
      qbuf[0] <= qbuf[1];
      qbuf[1] <= qbuf[2];
    end
  end

endmodule
`default_nettype wire

FILE: sim/regex_pattern_lexer_test.sv
module regex_pattern_lexer_test;

  localparam int unsigned MaxLen = 4096;
  localparam int unsigned CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  rpl_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rpl_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rpl_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  regex_pattern_lexer #(.MAX_LEN(MaxLen)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor copy of registers and pattern state
  logic [7:0] pr_lo, pr_hi, sp_lo, sp_hi;
  rpl_pkg::phase_t ph;
  logic in_cls, nl_seen, comma_hit, err_hold;
  logic [7:0] held, prev_c, first_brace, rng_lo;
  int unsigned pos, tok_start;

  rpl_pkg::out_item_t token_q[$];
  rpl_pkg::out_item_t step_toks[$];
  int errors = 0;
  int unsigned cycles = 0;
  int unsigned rx_idle = 0;
  bit calm = 0;      // no idling in the closing stretch
  bit hold_off = 0;  // long receiver stall request

  function automatic bit printable(logic [7:0] c);
    return (c >= pr_lo && c <= pr_hi) || (c >= sp_lo && c <= sp_hi);
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= rpl_pkg::CH_0 && c <= rpl_pkg::CH_9;
  endfunction

  function automatic int unsigned nxt(int unsigned p);
    return p < MaxLen ? p + 1 : p;
  endfunction

  function automatic rpl_pkg::kind_t op_kind(logic [7:0] c);
    case (c)
      "(": return rpl_pkg::K_LPAREN;
      ")": return rpl_pkg::K_RPAREN;
      "+": return rpl_pkg::K_PLUS;
      "?": return rpl_pkg::K_QUEST;
      "*": return rpl_pkg::K_STAR;
      ".": return rpl_pkg::K_ANY;
      "^": return rpl_pkg::K_CARET;
      "$": return rpl_pkg::K_DOLLAR;
      "|": return rpl_pkg::K_BAR;
      default: return rpl_pkg::K_BAD;
    endcase
  endfunction

  task automatic push_tok(rpl_pkg::kind_t k, rpl_pkg::err_t e, int unsigned s,
                          int unsigned t, logic [7:0] lo, logic [7:0] hi);
    rpl_pkg::out_item_t o;
    o.token_kind = k;
    o.error_code = e;
    o.span_start = s[rpl_pkg::SpanW-1:0];
    o.span_stop = t[rpl_pkg::SpanW-1:0];
    o.low_char = lo;
    o.high_char = hi;
    o.newline_flag = nl_seen;
    o.run_end = 1'b0;
    step_toks.push_back(o);
  endtask

  task automatic flag_err(rpl_pkg::err_t e, int unsigned stop);
    push_tok(rpl_pkg::K_BAD, e, tok_start, stop, 8'h00, 8'h00);
    err_hold = 1'b1;
  endtask

  task automatic clear_pattern();
    ph = rpl_pkg::PH_START; in_cls = 0; nl_seen = 0; comma_hit = 0; held = 0;
    prev_c = 0; first_brace = 0; rng_lo = 0; pos = 0; tok_start = 0;
    err_hold = 0;
  endtask

  task automatic take_literal(logic [7:0] c, int unsigned p);
    if (c == rpl_pkg::CH_NL) nl_seen = 1'b1;
    if (c == rpl_pkg::CH_DASH && in_cls && prev_c != rpl_pkg::CH_BSLASH) begin
      flag_err(rpl_pkg::E_BAD_RANGE, nxt(p));
      return;
    end
    held = c;
    ph = rpl_pkg::PH_LIT;
  endtask

  task automatic open_token(logic [7:0] c, int unsigned p);
    rpl_pkg::kind_t k;
    k = op_kind(c);
    tok_start = p;
    ph = rpl_pkg::PH_START;
    if (c == rpl_pkg::CH_BSLASH) begin
      ph = rpl_pkg::PH_ESC;
    end else if (c == rpl_pkg::CH_RBRACK) begin
      push_tok(rpl_pkg::K_CCLOSE, rpl_pkg::E_NONE, p, nxt(p), 0, 0);
      in_cls = 0;
    end else if (k != rpl_pkg::K_BAD || c == rpl_pkg::CH_LBRACK ||
                 c == rpl_pkg::CH_LBRACE || c == rpl_pkg::CH_RBRACE) begin
      if (in_cls) take_literal(c, p);
      else if (c == rpl_pkg::CH_LBRACK) begin
        push_tok(rpl_pkg::K_COPEN, rpl_pkg::E_NONE, p, nxt(p), 0, 0);
        in_cls = 1;
      end else if (c == rpl_pkg::CH_LBRACE) begin
        comma_hit = 0;
        first_brace = 0;
        ph = rpl_pkg::PH_REP;
      end else if (c == rpl_pkg::CH_RBRACE) flag_err(rpl_pkg::E_STRAY, nxt(p));
      else push_tok(k, rpl_pkg::E_NONE, p, nxt(p), 0, 0);
    end else if (printable(c)) begin
      take_literal(c, p);
    end else begin
      flag_err(rpl_pkg::E_INVALID, nxt(p));
    end
  endtask

  task automatic lex_byte(logic [7:0] c, int unsigned p);
    case (ph)
      rpl_pkg::PH_LIT: begin
        if (c == rpl_pkg::CH_DASH && in_cls) begin
          rng_lo = held;
          ph = rpl_pkg::PH_RANGE;
        end else begin
          push_tok(rpl_pkg::K_LIT, rpl_pkg::E_NONE, tok_start, p, held, held);
          open_token(c, p);
        end
      end
      rpl_pkg::PH_ESC: begin
        tok_start = p;
        take_literal(c, p);
      end
      rpl_pkg::PH_RANGE: begin
        if (c == rpl_pkg::CH_BSLASH) ph = rpl_pkg::PH_RANGE_ESC;
        else if (printable(c) && c != rpl_pkg::CH_LBRACK && c != rpl_pkg::CH_RBRACK) begin
          push_tok(rpl_pkg::K_RANGE, rpl_pkg::E_NONE, tok_start, nxt(p), rng_lo, c);
          ph = rpl_pkg::PH_START;
        end else flag_err(rpl_pkg::E_BAD_RANGE, nxt(p));
      end
      rpl_pkg::PH_RANGE_ESC: begin
        if (printable(c)) begin
          push_tok(rpl_pkg::K_RANGE, rpl_pkg::E_NONE, tok_start, nxt(p), rng_lo, c);
          ph = rpl_pkg::PH_START;
        end else flag_err(rpl_pkg::E_BAD_RANGE, nxt(p));
      end
      rpl_pkg::PH_REP: begin
        if (p == tok_start + 1) first_brace = c;
        if (c == rpl_pkg::CH_RBRACE) begin
          if (!digit(prev_c) && !digit(first_brace)) flag_err(rpl_pkg::E_EMPTY_REP, nxt(p));
          else begin
            push_tok(rpl_pkg::K_REP, rpl_pkg::E_NONE, tok_start, nxt(p), 0, 0);
            ph = rpl_pkg::PH_START;
          end
        end else if (c == rpl_pkg::CH_COMMA) begin
          if (comma_hit) flag_err(rpl_pkg::E_COMMA, nxt(p));
          else comma_hit = 1;
        end else if (!digit(c)) flag_err(rpl_pkg::E_DIGIT, nxt(p));
      end
      default: open_token(c, p);
    endcase
  endtask

  task automatic close_pattern();
    case (ph)
      rpl_pkg::PH_LIT:
        push_tok(rpl_pkg::K_LIT, rpl_pkg::E_NONE, tok_start, pos, held, held);
      rpl_pkg::PH_ESC, rpl_pkg::PH_RANGE_ESC: flag_err(rpl_pkg::E_TRAIL_ESC, pos);
      rpl_pkg::PH_RANGE: push_tok(rpl_pkg::K_BAD, rpl_pkg::E_NONE, tok_start, pos, 0, 0);
      rpl_pkg::PH_REP: flag_err(rpl_pkg::E_OPEN_REP, pos);
      default: ;
    endcase
    if (!err_hold) push_tok(rpl_pkg::K_END, rpl_pkg::E_NONE, pos, pos, 0, 0);
  endtask

  // returns tokens caused by one byte, queued as expectations
  task automatic predict_tokens(rpl_pkg::in_item_t it);
    step_toks.delete();
    if (err_hold) begin
      if (it.is_last) clear_pattern();
      return;
    end
    lex_byte(it.pattern_char, pos);
    prev_c = it.pattern_char;
    pos = nxt(pos);
    if (it.is_last) begin
      if (!err_hold) close_pattern();
      clear_pattern();
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].run_end = 1'b1;
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endtask

  // --- sender ---
  task automatic send_byte(logic [7:0] c, bit last);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_data <= '{pattern_char: c, is_last: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tokens('{pattern_char: c, is_last: last});
    @(negedge clk);
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (token_q.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [rpl_pkg::CfgIdxW-1:0] idx, logic [7:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rpl_pkg::REG_PRINT_LO: pr_lo = v;
      rpl_pkg::REG_PRINT_HI: pr_hi = v;
      rpl_pkg::REG_SPACE_LO: sp_lo = v;
      default: sp_hi = v;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
    write_reg(rpl_pkg::REG_PRINT_LO, a);
    write_reg(rpl_pkg::REG_PRINT_HI, b);
    write_reg(rpl_pkg::REG_SPACE_LO, c);
    write_reg(rpl_pkg::REG_SPACE_HI, d);
    cfg_valid <= 1'b0;
  endtask

  // well-formed pattern with random content, sometimes broken
  function automatic string rand_pattern();
    string s;
    string atoms[14];
    int n;
    atoms = '{"a", "\\", "[", "]", "{", "}", "(", ")", "-", "0", ",", "*", "|", "."};
    s = "";
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: s = {s, "[a-z]"};
        1: s = {s, $sformatf("{%0d,%0d}", $urandom_range(0, 9), $urandom_range(0, 99))};
        2: s = {s, "(", atoms[$urandom_range(0, 13)], ")"};
        3: s = {s, "\\", string'(byte'($urandom_range(0, 255)))};
        4: s = {s, "[", string'(byte'($urandom_range(32, 126))), "-",
                string'(byte'($urandom_range(0, 255))), "]"};
        5: s = {s, string'(byte'($urandom_range(0, 255)))};
        6: s = {s, atoms[$urandom_range(0, 13)]};
        default: s = {s, string'(byte'($urandom_range(33, 126))), "+"};
      endcase
    end
    return s;
  endfunction

  // --- receiver ---
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (rx_idle > 0) begin
      out_stall <= 1'b1;
      rx_idle <= rx_idle - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      rx_idle <= $urandom_range(0, 15);
    end else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected token expected none actual %p", $time, out_data);
        errors++;
      end else begin
        rpl_pkg::out_item_t e;
        e = token_q.pop_front();
        if (out_data !== e) begin
          $display("%0t: token mismatch expected %p actual %p", $time, e, out_data);
          errors++;
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  typedef struct {
    logic [7:0] c;
    bit last;
    bit known;
    rpl_pkg::kind_t kind;
    rpl_pkg::err_t err;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    rpl_pkg::out_item_t peek;
    pr_lo = 32; pr_hi = 126; sp_lo = 9; sp_hi = 13;
    clear_pattern();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: kind/err typed where obvious (first token of the byte)
    rows = '{
      '{8'h00, 1, 1, rpl_pkg::K_BAD, rpl_pkg::E_INVALID},
      '{8'hFF, 1, 1, rpl_pkg::K_BAD, rpl_pkg::E_INVALID},
      '{"}", 1, 1, rpl_pkg::K_BAD, rpl_pkg::E_STRAY},
      '{"\\", 1, 1, rpl_pkg::K_BAD, rpl_pkg::E_TRAIL_ESC},
      '{"{", 1, 1, rpl_pkg::K_BAD, rpl_pkg::E_OPEN_REP},
      '{"(", 0, 1, rpl_pkg::K_LPAREN, rpl_pkg::E_NONE},
      '{"[", 0, 1, rpl_pkg::K_COPEN, rpl_pkg::E_NONE},
      '{"a", 0, 0, rpl_pkg::K_END, rpl_pkg::E_NONE},
      '{"-", 0, 0, rpl_pkg::K_END, rpl_pkg::E_NONE},
      '{"\\", 0, 0, rpl_pkg::K_END, rpl_pkg::E_NONE},
      '{"]", 0, 0, rpl_pkg::K_END, rpl_pkg::E_NONE},
      '{"]", 0, 0, rpl_pkg::K_END, rpl_pkg::E_NONE},
      '{"{", 0, 0, rpl_pkg::K_END, rpl_pkg::E_NONE},
      '{",", 0, 0, rpl_pkg::K_END, rpl_pkg::E_NONE},
      '{"}", 1, 1, rpl_pkg::K_BAD, rpl_pkg::E_EMPTY_REP},
      '{"{", 0, 0, rpl_pkg::K_END, rpl_pkg::E_NONE},
      '{"3", 0, 0, rpl_pkg::K_END, rpl_pkg::E_NONE},
      '{",", 0, 0, rpl_pkg::K_END, rpl_pkg::E_NONE},
      '{",", 0, 1, rpl_pkg::K_BAD, rpl_pkg::E_COMMA},
      '{"z", 1, 0, rpl_pkg::K_END, rpl_pkg::E_NONE},
      '{"[", 0, 1, rpl_pkg::K_COPEN, rpl_pkg::E_NONE},
      '{"\n", 0, 0, rpl_pkg::K_END, rpl_pkg::E_NONE},
      '{"-", 1, 0, rpl_pkg::K_END, rpl_pkg::E_NONE}
    };
    foreach (rows[i]) begin
      send_byte(rows[i].c, rows[i].last);
      if (rows[i].known) begin
        if (step_toks.size() == 0) begin
          $display("%0t: row %0d expected %s/%s actual none", $time, i,
                   rows[i].kind.name(), rows[i].err.name());
          errors++;
        end else begin
          peek = step_toks[0];
          if (peek.token_kind != rows[i].kind || peek.error_code != rows[i].err) begin
            $display("%0t: row %0d expected %s/%s actual %s/%s", $time, i,
                     rows[i].kind.name(), rows[i].err.name(),
                     peek.token_kind.name(), peek.error_code.name());
            errors++;
          end
        end
      end
    end
    send_str("{x}");
    send_str("[\\]-\\");
    send_str("[a-\\\001]");
    drain();

    // receiver holds off while sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 20; i++) send_str("(+)");
    join
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_regs(8'd0, 8'd255, 8'd255, 8'd0);
        1: set_regs(8'd255, 8'd0, 8'd0, 8'd0);
        2: set_regs(8'd48, 8'd122, 8'd10, 8'd10);
        default: set_regs(8'd32, 8'd126, 8'd9, 8'd13);
      endcase
      if (phase == 3) calm = 1;
      for (int p = 0; p < 6; p++) begin
        if ($urandom_range(0, 4) == 0) begin
          for (int k = $urandom_range(1, 8); k > 0; k--)
            send_byte(8'($urandom_range(0, 255)), k == 1 && $urandom_range(0, 1));
          send_byte("a", 1);
        end else send_str(rand_pattern());
      end
      drain();
    end

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
